// File: rtl/rsgv_pkg.sv
// Shared types and constants of the reed sensor gate voter.
package rsgv_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int MASK_W     = 4;

  localparam logic       KIND_EVENT = 1'b0;
  localparam logic       KIND_TICK  = 1'b1;
  localparam logic       MODE_MAJ   = 1'b1;
  localparam logic [7:0] FAULT_LIMIT_RST   = 8'd200;
  localparam logic [15:0] CONFIRM_DELAY_RST = 16'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOTE_MODE     = 2'd0,
    REG_NC_MASK       = 2'd1,
    REG_FAULT_LIMIT   = 2'd2,
    REG_CONFIRM_DELAY = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RENUM,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic walk;
    logic renum;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic expire;
    logic last;
    logic same;
  } status_t;

endpackage

// File: rtl/rsgv_in_if.sv
// Input channel carrying sensor events and millisecond ticks.
interface rsgv_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] sensor_index;
  logic       contact_closed;

  modport source (output valid, kind, sensor_index, contact_closed, input ready);
  modport sink (input valid, kind, sensor_index, contact_closed, output ready);
endinterface

// File: rtl/rsgv_out_if.sv
// Output channel carrying one gate evaluation result.
interface rsgv_out_if;
  logic       valid;
  logic       ready;
  logic       gate_shut;
  logic       phase_closing;
  logic       all_same_state;
  logic [3:0] triggered_mask;
  logic [3:0] out_of_order_mask;
  logic [3:0] masked_mask;

  modport source (output valid, gate_shut, phase_closing, all_same_state,
                  triggered_mask, out_of_order_mask, masked_mask, input ready);
  modport sink (input valid, gate_shut, phase_closing, all_same_state,
                triggered_mask, out_of_order_mask, masked_mask, output ready);
endinterface

// File: rtl/reed_sensor_gate_voter.sv
// Top level of the reed sensor gate voter.
//
// Items arrive on in_i: a sensor event (kind 0, sensor_index, contact_closed)
// or a millisecond tick (kind 1). Results leave on res_o, one per expiry of
// the confirm timer. An item is taken at a clock edge where valid and ready
// are both high. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must do so only while the block is idle, which the
// block does not enforce. An event or a non-expiring tick is handled as it
// is taken. An expiring tick starts an evaluation: a walk over the sensors
// for the sequence check and vote, a walk that renumbers the tickets when
// all or no sensors agree, and a load of the result register. The sensor
// walk takes one sensor per cycle through a single compare unit, and the
// renumber walk is skipped in every other case.
// Input ready is high only while the block waits for an item.
// Reset clears all sensor state, the timer and the ticket counter, and loads
// the default fault limit of 200 and confirm delay of 2000 ms.
// When the receiver stalls, the result holds in the output register and the
// block still takes items; a second result waits until the first transfer.
module reed_sensor_gate_voter #(
  parameter int NUM_SENSORS = 4,
  parameter int TICKET_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rsgv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rsgv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rsgv_in_if.sink                         in_i,
  rsgv_out_if.source                      res_o
);
  import rsgv_pkg::*;

  cmd_t    cmd;
  status_t status;

  rsgv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rsgv_dpath #(
    .NUM_SENSORS (NUM_SENSORS),
    .TICKET_BITS (TICKET_BITS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .kind_i              (in_i.kind),
    .sensor_index_i      (in_i.sensor_index),
    .contact_closed_i    (in_i.contact_closed),
    .cmd_i               (cmd),
    .status_o            (status),
    .gate_shut_o         (res_o.gate_shut),
    .phase_closing_o     (res_o.phase_closing),
    .all_same_state_o    (res_o.all_same_state),
    .triggered_mask_o    (res_o.triggered_mask),
    .out_of_order_mask_o (res_o.out_of_order_mask),
    .masked_mask_o       (res_o.masked_mask)
  );
endmodule

// File: rtl/rsgv_ctrl.sv
// Controller state machine that sequences event handling, evaluation and output.
module rsgv_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  rsgv_pkg::status_t status_i,
  output rsgv_pkg::cmd_t    cmd_o
);
  import rsgv_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.expire) state_d = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.last) state_d = S_RENUM;
      end
      S_RENUM: begin
        if (!status_i.same) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.renum = 1'b1;
          if (status_i.last) state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_walk_to_renum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && status_i.last) |=> (state_q == S_RENUM))
    else $error("walk did not end in the renumber state");
  a_expire_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && status_i.expire) |=> (state_q == S_WALK))
    else $error("expiring tick did not start the walk");
  a_load_keeps_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && state_q != S_EMIT) |=> out_valid_q)
    else $error("pending result was dropped");
endmodule

// File: rtl/rsgv_dpath.sv
// Datapath holding sensor state, configuration, the walk unit and the result register.
module rsgv_dpath #(
  parameter int NUM_SENSORS = 4,
  parameter int TICKET_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rsgv_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rsgv_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              kind_i,
  input  logic [1:0]                        sensor_index_i,
  input  logic                              contact_closed_i,
  input  rsgv_pkg::cmd_t                    cmd_i,
  output rsgv_pkg::status_t                 status_o,
  output logic                              gate_shut_o,
  output logic                              phase_closing_o,
  output logic                              all_same_state_o,
  output logic [rsgv_pkg::MASK_W-1:0]       triggered_mask_o,
  output logic [rsgv_pkg::MASK_W-1:0]       out_of_order_mask_o,
  output logic [rsgv_pkg::MASK_W-1:0]       masked_mask_o
);
  import rsgv_pkg::*;

  localparam int SIDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int CNT_W  = $clog2(NUM_SENSORS + 1);
  localparam int THRESH = (NUM_SENSORS % 2 == 1) ? NUM_SENSORS / 2 + 1 : NUM_SENSORS / 2;
  localparam logic [SIDX_W-1:0] LAST_IDX = SIDX_W'(NUM_SENSORS - 1);
  localparam logic [CNT_W-1:0]  CNT_ALL  = CNT_W'(NUM_SENSORS);
  localparam logic [CNT_W-1:0]  CNT_TH   = CNT_W'(THRESH);

  logic                    mode_q;
  logic [MASK_W-1:0]       nc_mask_q;
  logic [7:0]              limit_q;
  logic [15:0]             delay_q;

  logic [NUM_SENSORS-1:0]  level_q, masked_q, ooo_q, trig_q;
  logic [TICKET_BITS-1:0]  tickets_q [NUM_SENSORS];
  logic [7:0]              counts_q [NUM_SENSORS];
  logic [SIDX_W-1:0]       last_q;
  logic [TICKET_BITS-1:0]  ticket_q;
  logic [15:0]             countdown_q;
  logic                    armed_q;

  logic [SIDX_W-1:0]       k_q;
  logic                    closing_q;
  logic                    have_prev_q;
  logic [TICKET_BITS-1:0]  prev_ticket_q;
  logic [CNT_W-1:0]        count_q;

  logic                    gate_q, closing_out_q, same_out_q;
  logic [MASK_W-1:0]       trig_out_q, ooo_out_q, masked_out_q;

  logic [NUM_SENSORS-1:0]  nc_vec, act_vec;
  logic [MASK_W-1:0]       trig_vec, ooo_vec, masked_vec;
  logic [SIDX_W-1:0]       ev_idx, wi;
  logic                    ev_ok, tick_acc, expire;
  logic [7:0]              new_cnt;
  logic [TICKET_BITS-1:0]  ticket_inc;
  logic                    w_act, w_cond, w_ooo_set, w_ooo_new, w_trig, want;
  logic                    gate, same;

  for (genvar j = 0; j < NUM_SENSORS; j++) begin : g_act
    if (j < MASK_W) begin : g_nc
      assign nc_vec[j] = nc_mask_q[j];
    end else begin : g_no
      assign nc_vec[j] = 1'b0;
    end
    assign act_vec[j] = nc_vec[j] ^ level_q[j];
  end

  for (genvar j = 0; j < MASK_W; j++) begin : g_out
    if (j < NUM_SENSORS) begin : g_have
      assign trig_vec[j]   = trig_q[j];
      assign ooo_vec[j]    = ooo_q[j];
      assign masked_vec[j] = masked_q[j];
    end else begin : g_none
      assign trig_vec[j]   = 1'b0;
      assign ooo_vec[j]    = 1'b0;
      assign masked_vec[j] = 1'b0;
    end
  end

  always_comb begin
    ev_idx     = SIDX_W'(sensor_index_i);
    ev_ok      = cmd_i.accept && (kind_i == KIND_EVENT) &&
                 (32'(sensor_index_i) < 32'(NUM_SENSORS)) && !masked_q[ev_idx];
    tick_acc   = cmd_i.accept && (kind_i == KIND_TICK) && armed_q;
    expire     = (kind_i == KIND_TICK) && armed_q && (countdown_q <= 16'd1);
    new_cnt    = counts_q[ev_idx] + 8'd1;
    ticket_inc = (ticket_q == '1) ? ticket_q : ticket_q + TICKET_BITS'(1);

    wi        = closing_q ? k_q : LAST_IDX - k_q;
    w_act     = act_vec[wi];
    w_cond    = !masked_q[wi] && !ooo_q[wi] && (w_act == closing_q);
    w_ooo_set = w_cond && have_prev_q && (tickets_q[wi] < prev_ticket_q);
    w_ooo_new = ooo_q[wi] | w_ooo_set;
    want      = (mode_q == MODE_MAJ) ? closing_q : 1'b1;
    w_trig    = !masked_q[wi] && !w_ooo_new && (w_act == want);

    if (mode_q == MODE_MAJ) begin
      gate = (count_q >= CNT_TH) ? closing_q : !closing_q;
    end else begin
      gate = (count_q == CNT_ALL);
    end
    same = (count_q == '0) || (count_q == CNT_ALL);
  end

  assign status_o.expire = expire;
  assign status_o.last   = (k_q == LAST_IDX);
  assign status_o.same   = same;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      nc_mask_q <= '0;
      limit_q   <= FAULT_LIMIT_RST;
      delay_q   <= CONFIRM_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_VOTE_MODE:     mode_q    <= cfg_data_i[0];
        REG_NC_MASK:       nc_mask_q <= cfg_data_i[MASK_W-1:0];
        REG_FAULT_LIMIT:   limit_q   <= cfg_data_i[7:0];
        REG_CONFIRM_DELAY: delay_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q       <= '0;
      masked_q      <= '0;
      ooo_q         <= '0;
      trig_q        <= '0;
      for (int s = 0; s < NUM_SENSORS; s++) begin
        tickets_q[s] <= '0;
        counts_q[s]  <= '0;
      end
      last_q        <= '0;
      ticket_q      <= '0;
      countdown_q   <= '0;
      armed_q       <= 1'b0;
      k_q           <= '0;
      closing_q     <= 1'b0;
      have_prev_q   <= 1'b0;
      prev_ticket_q <= '0;
      count_q       <= '0;
    end else begin
      if (ev_ok) begin
        tickets_q[ev_idx] <= ticket_inc;
        ticket_q          <= ticket_inc;
        level_q[ev_idx]   <= contact_closed_i;
        counts_q[ev_idx]  <= new_cnt;
        ooo_q[ev_idx]     <= 1'b0;
        last_q            <= ev_idx;
        if (new_cnt == limit_q) masked_q[ev_idx] <= 1'b1;
        countdown_q       <= delay_q;
        armed_q           <= 1'b1;
      end
      if (tick_acc) begin
        if (countdown_q > 16'd1) begin
          countdown_q <= countdown_q - 16'd1;
        end else begin
          countdown_q <= '0;
          armed_q     <= 1'b0;
          closing_q   <= act_vec[last_q];
          have_prev_q <= 1'b0;
          count_q     <= '0;
          k_q         <= '0;
        end
      end
      if (cmd_i.walk) begin
        ooo_q[wi]    <= w_ooo_new;
        trig_q[wi]   <= w_trig;
        counts_q[wi] <= '0;
        count_q      <= count_q + CNT_W'(w_trig);
        if (w_cond && !w_ooo_set) begin
          have_prev_q   <= 1'b1;
          prev_ticket_q <= tickets_q[wi];
        end
        k_q <= status_o.last ? '0 : k_q + SIDX_W'(1);
      end
      if (cmd_i.renum) begin
        tickets_q[wi] <= TICKET_BITS'(k_q) + TICKET_BITS'(1);
        ticket_q      <= TICKET_BITS'(k_q) + TICKET_BITS'(1);
        k_q           <= status_o.last ? '0 : k_q + SIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      gate_q        <= gate;
      closing_out_q <= closing_q;
      same_out_q    <= same;
      trig_out_q    <= trig_vec;
      ooo_out_q     <= ooo_vec;
      masked_out_q  <= masked_vec;
    end
  end

  assign gate_shut_o         = gate_q;
  assign phase_closing_o     = closing_out_q;
  assign all_same_state_o    = same_out_q;
  assign triggered_mask_o    = trig_out_q;
  assign out_of_order_mask_o = ooo_out_q;
  assign masked_mask_o       = masked_out_q;

  a_mask_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((masked_q & $past(masked_q)) == $past(masked_q)))
    else $error("a masked sensor was unmasked");
  a_ticket_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($past(cmd_i.renum) || (ticket_q >= $past(ticket_q))))
    else $error("ticket counter went back outside renumbering");
  a_walk_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.walk && status_o.last) |=> (k_q == '0))
    else $error("walk index did not return to zero");
  a_expire_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && expire) |=> !armed_q)
    else $error("confirm timer still armed after expiry");
endmodule

// File: test/tb_reed_sensor_gate_voter.sv
// Self-checking testbench of the reed sensor gate voter with its own gate predictor.
module tb_reed_sensor_gate_voter;
  import rsgv_pkg::*;

  localparam int          SENSORS       = 4;
  localparam int          MAJORITY      = SENSORS / 2;
  localparam logic [15:0] TICKET_MAX    = '1;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          DRAIN_LIMIT   = 5000;

  typedef struct packed {
    logic       gate_shut;
    logic       phase_closing;
    logic       all_same_state;
    logic [3:0] triggered_mask;
    logic [3:0] out_of_order_mask;
    logic [3:0] masked_mask;
  } verdict_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rsgv_in_if  in_if ();
  rsgv_out_if res_if ();

  reed_sensor_gate_voter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .res_o      (res_if)
  );

  always #5 clk_i = ~clk_i;

  logic        cfg_vote_mode     = 1'b0;
  logic [3:0]  cfg_nc_mask       = '0;
  logic [7:0]  cfg_fault_limit   = FAULT_LIMIT_RST;
  logic [15:0] cfg_confirm_delay = CONFIRM_DELAY_RST;

  logic [3:0]  sensor_level        = '0;
  logic [15:0] sensor_ticket [SENSORS] = '{default: '0};
  logic [7:0]  sensor_events [SENSORS] = '{default: '0};
  logic [3:0]  sensor_masked       = '0;
  logic [3:0]  sensor_out_of_order = '0;
  logic [1:0]  last_reporter       = '0;
  logic [15:0] ticket_count        = '0;
  logic [15:0] confirm_left        = '0;
  logic        confirm_running     = 1'b0;

  verdict_t pending_verdicts [$];
  int       failures          = 0;
  int       live_items        = 0;
  bit       tx_idle_on        = 1'b1;
  bit       rx_idle_on        = 1'b1;
  int       rx_hold_request   = 0;
  int       rx_hold_left      = 0;

  function automatic logic is_active(int s);
    return cfg_nc_mask[s] ^ sensor_level[s];
  endfunction

  function automatic logic [15:0] next_ticket();
    if (ticket_count != TICKET_MAX) ticket_count++;
    return ticket_count;
  endfunction

  task automatic judge_gate(output verdict_t v);
    logic closing;
    logic have_prev;
    logic want_level;
    int   prev;
    int   idx;
    int   votes;
    closing   = is_active(int'(last_reporter));
    have_prev = 1'b0;
    prev      = 0;
    votes     = 0;
    for (int k = 0; k < SENSORS; k++) begin
      idx = closing ? k : SENSORS - 1 - k;
      if (!sensor_masked[idx] && !sensor_out_of_order[idx] && is_active(idx) == closing) begin
        if (!have_prev) begin
          have_prev = 1'b1;
          prev      = idx;
        end else if (sensor_ticket[idx] < sensor_ticket[prev]) begin
          sensor_out_of_order[idx] = 1'b1;
        end else begin
          prev = idx;
        end
      end
    end
    want_level = (cfg_vote_mode == MODE_MAJ) ? closing : 1'b1;
    v = '0;
    for (int i = 0; i < SENSORS; i++) begin
      v.triggered_mask[i] = !sensor_masked[i] && !sensor_out_of_order[i] &&
                            is_active(i) == want_level;
      if (v.triggered_mask[i]) votes++;
      sensor_events[i] = '0;
    end
    if (cfg_vote_mode == MODE_MAJ) begin
      v.gate_shut = (votes >= MAJORITY) ? closing : !closing;
    end else begin
      v.gate_shut = (votes == SENSORS);
    end
    v.all_same_state = (votes == 0) || (votes == SENSORS);
    if (v.all_same_state) begin
      ticket_count = '0;
      for (int k = 0; k < SENSORS; k++) begin
        sensor_ticket[closing ? k : SENSORS - 1 - k] = next_ticket();
      end
    end
    v.phase_closing     = closing;
    v.out_of_order_mask = sensor_out_of_order;
    v.masked_mask       = sensor_masked;
  endtask

  task automatic predict_item(logic kind, logic [1:0] s, logic closed);
    verdict_t v;
    if (kind == KIND_EVENT) begin
      if (sensor_masked[s]) return;
      sensor_ticket[s]       = next_ticket();
      sensor_level[s]        = closed;
      sensor_events[s]       = sensor_events[s] + 8'd1;
      sensor_out_of_order[s] = 1'b0;
      last_reporter          = s;
      if (sensor_events[s] == cfg_fault_limit) sensor_masked[s] = 1'b1;
      confirm_left    = cfg_confirm_delay;
      confirm_running = 1'b1;
    end else begin
      if (!confirm_running) return;
      if (confirm_left > 16'd1) begin
        confirm_left--;
      end else begin
        confirm_left    = '0;
        confirm_running = 1'b0;
        judge_gate(v);
        pending_verdicts.push_back(v);
      end
    end
    live_items++;
  endtask

  task automatic send_item(logic kind, logic [1:0] s, logic closed);
    while (tx_idle_on && $urandom_range(99) < 27) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.kind           <= kind;
    in_if.sensor_index   <= s;
    in_if.contact_closed <= closed;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_item(kind, s, closed);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_verdicts.size() != 0) begin
      $error("%0d expected results never arrived", pending_verdicts.size());
      failures++;
      pending_verdicts.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(logic mode, logic [3:0] nc, logic [7:0] limit,
                              logic [15:0] delay);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_VOTE_MODE;
    cfg_data_i <= CFG_DATA_W'(mode);
    @(posedge clk_i);
    cfg_idx_i  <= REG_NC_MASK;
    cfg_data_i <= CFG_DATA_W'(nc);
    @(posedge clk_i);
    cfg_idx_i  <= REG_FAULT_LIMIT;
    cfg_data_i <= CFG_DATA_W'(limit);
    @(posedge clk_i);
    cfg_idx_i  <= REG_CONFIRM_DELAY;
    cfg_data_i <= delay;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_vote_mode     = mode;
    cfg_nc_mask       = nc;
    cfg_fault_limit   = limit;
    cfg_confirm_delay = delay;
  endtask

  task automatic send_sequence();
    int   burst;
    logic base;
    burst = $urandom_range(1, 6);
    base  = 1'($urandom_range(1));
    repeat (burst) begin
      send_item(KIND_EVENT, 2'($urandom_range(3)), ($urandom_range(3) == 0) ? ~base : base);
    end
    while (confirm_running) begin
      send_item(KIND_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)));
    end
  endtask

  task automatic compare_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      $error("result transfer with no result expected");
      failures++;
      return;
    end
    want = pending_verdicts.pop_front();
    compare_field("gate_shut", 4'(want.gate_shut), 4'(res_if.gate_shut));
    compare_field("phase_closing", 4'(want.phase_closing), 4'(res_if.phase_closing));
    compare_field("all_same_state", 4'(want.all_same_state), 4'(res_if.all_same_state));
    compare_field("triggered_mask", want.triggered_mask, res_if.triggered_mask);
    compare_field("out_of_order_mask", want.out_of_order_mask, res_if.out_of_order_mask);
    compare_field("masked_mask", want.masked_mask, res_if.masked_mask);
  endtask

  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) check_verdict();
  end

  always @(posedge clk_i) begin
    if (rx_hold_request > 0) begin
      rx_hold_left    = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= !(rx_idle_on && $urandom_range(99) < 27);
    end
  end

  task automatic test_directed();
    send_item(KIND_TICK, 2'd3, 1'b1);
    send_item(KIND_EVENT, 2'd0, 1'b1);
    send_item(KIND_TICK, 2'd0, 1'b0);
    write_config(1'b0, 4'h0, 8'd255, 16'd65535);
    send_item(KIND_EVENT, 2'd1, 1'b1);
    send_item(KIND_TICK, 2'd1, 1'b0);
    write_config(1'b0, 4'h0, 8'd255, 16'd1);
    for (int s = 0; s < SENSORS; s++) send_item(KIND_EVENT, 2'(s), 1'b1);
    send_item(KIND_TICK, 2'd2, 1'b1);
    // With every pin normally closed and no delay, the first tick evaluates.
    write_config(1'b0, 4'hF, 8'd200, 16'd0);
    send_item(KIND_EVENT, 2'd3, 1'b1);
    send_item(KIND_EVENT, 2'd2, 1'b0);
    send_item(KIND_TICK, 2'd0, 1'b0);
    // Sensor 2 reports first in a closing phase and is flagged out of sequence.
    write_config(MODE_MAJ, 4'h0, 8'd255, 16'd2);
    send_item(KIND_EVENT, 2'd2, 1'b1);
    send_item(KIND_EVENT, 2'd0, 1'b1);
    send_item(KIND_EVENT, 2'd1, 1'b1);
    send_item(KIND_TICK, 2'd0, 1'b0);
    send_item(KIND_TICK, 2'd0, 1'b0);
    send_item(KIND_EVENT, 2'd3, 1'b0);
    send_item(KIND_EVENT, 2'd0, 1'b0);
    send_item(KIND_TICK, 2'd1, 1'b0);
    send_item(KIND_TICK, 2'd1, 1'b0);
  endtask

  task automatic test_random_traffic();
    int target;
    int phase_end;
    target = live_items + 120;
    while (live_items < target) begin
      write_config(1'($urandom_range(1)), 4'($urandom_range(15)),
                   8'($urandom_range(100, 255)),
                   ($urandom_range(7) == 0) ? 16'($urandom_range(20, 40)) :
                                              16'($urandom_range(0, 5)));
      phase_end = live_items + 40;
      while (live_items < phase_end) begin
        if ($urandom_range(99) < 80) begin
          send_sequence();
        end else begin
          send_item(1'($urandom_range(1)), 2'($urandom_range(3)), 1'($urandom_range(1)));
        end
      end
    end
  endtask

  task automatic test_steady_stream();
    write_config(1'($urandom_range(1)), 4'($urandom_range(15)), 8'd255, 16'd1);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (15) send_sequence();
    drain();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    write_config(1'b0, 4'($urandom_range(15)), 8'd255, 16'd1);
    rx_hold_request = 400;
    repeat (8) begin
      send_item(KIND_EVENT, 2'($urandom_range(3)), 1'($urandom_range(1)));
      send_item(KIND_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)));
    end
    drain();
  endtask

  task automatic test_fault_masking();
    // A limit of zero is only met when the event count wraps.
    write_config(1'b0, 4'h0, 8'd0, 16'd3);
    repeat (257) send_item(KIND_EVENT, 2'd3, 1'($urandom_range(1)));
    repeat (3) send_item(KIND_TICK, 2'd0, 1'b0);
    write_config(MODE_MAJ, 4'h0, 8'd1, 16'd3);
    send_item(KIND_EVENT, 2'd2, 1'b1);
    send_item(KIND_EVENT, 2'd0, 1'b1);
    send_item(KIND_TICK, 2'd0, 1'b0);
    // An event on a masked sensor must not restart the confirm timer.
    send_item(KIND_EVENT, 2'd2, 1'b0);
    send_item(KIND_TICK, 2'd0, 1'b0);
    send_item(KIND_TICK, 2'd0, 1'b0);
    write_config(1'b0, 4'h5, 8'd255, 16'd2);
    repeat (10) send_sequence();
  endtask

  initial begin
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= REG_VOTE_MODE;
    cfg_data_i           <= '0;
    in_if.valid          <= 1'b0;
    in_if.kind           <= KIND_EVENT;
    in_if.sensor_index   <= '0;
    in_if.contact_closed <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    test_steady_stream();
    test_backpressure();
    test_fault_masking();
    drain();
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule
